// ===== sv/hsc_pkg.sv =====
// ============================================================================
// hsc_pkg
// Shared types, sizes and register codes for the 3x3 heat stencil block.
// ============================================================================
package hsc_pkg;

  // Grid limits
  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  // Field widths
  localparam int unsigned SAMPLE_W   = 20;
  localparam int unsigned WEIGHT_W   = 16;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned CFG_IDX_W  = 3;

  // Counter widths: column index, width plus one, height plus one
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 2);
  localparam int unsigned HGT_W = $clog2(MAX_HEIGHT + 2);

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH    = 3'd0,
    CFG_GRID_HEIGHT   = 3'd1,
    CFG_PAD_VALUE     = 3'd2,
    CFG_WEIGHT_CORNER = 3'd3,
    CFG_WEIGHT_EDGE   = 3'd4,
    CFG_WEIGHT_CENTER = 3'd5
  } cfg_reg_t;

  // Item kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_FLUSH  = 1'b1;

  // Reset values of the registers
  localparam int unsigned RST_WIDTH  = 64;
  localparam int unsigned RST_HEIGHT = 64;
  localparam logic signed [SAMPLE_W-1:0] RST_PAD = 20'sd7680;   // 30.0
  localparam logic [WEIGHT_W-1:0] RST_W_CORNER = 16'd3277;      // 0.05
  localparam logic [WEIGHT_W-1:0] RST_W_EDGE   = 16'd6554;      // 0.1
  localparam logic [WEIGHT_W-1:0] RST_W_CENTER = 16'd26214;     // 0.4

  typedef struct packed {
    logic                       kind;
    logic signed [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       row_last;
    logic                       grid_last;
  } out_item_t;

  // Clamp a written dimension to 1 .. limit
  function automatic logic [31:0] clamp_dim(input logic [DIM_W-1:0] v,
                                            input int unsigned limit);
    logic [31:0] r;
    r = 32'(v);
    if (v == '0) begin
      r = 32'd1;
    end else if (r > limit) begin
      r = limit;
    end
    return r;
  endfunction

endpackage

// ===== sv/hsc_ram.sv =====
// ============================================================================
// hsc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module hsc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and read old contents on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/heat_stencil_conv3x3.sv =====
// ============================================================================
// heat_stencil_conv3x3
// One heat-diffusion pass: 3x3 weighted stencil over a raster grid with
// constant padding, line stores held in one RAM of two 20-bit halves.
// ============================================================================
//
//  channel | ports                         | direction | beat
//  --------+-------------------------------+-----------+------------------------
//  in      | in_valid in_ready in_data     | in        | one cell or flush item
//  out     | out_valid out_ready out_data  | out       | one new cell value
//  cfg     | cfg_valid cfg_ready cfg_index | in        | one register write
//          | cfg_wdata                     |           |
//
//  One item per cycle while no stalled result holds stage 1. The result for cell k
//  is offered once item k+width+1 is taken and has passed the line RAM read,
//  window sum, multiply and accumulate stages and the output register.
//  Reset clears control only; the line RAM is never cleared, as rows outside
//  the grid are replaced by the pad value by position.
//  A stalled output holds only the stages behind it that carry results;
//  items that give no result keep flowing through the empty stages.
//
module heat_stencil_conv3x3 import hsc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int unsigned LINE_W = 2 * SAMPLE_W;
  localparam int unsigned SUM_W  = SAMPLE_W + 2;
  localparam int unsigned PROD_W = SUM_W + WEIGHT_W + 1;
  localparam int unsigned ACC_W  = PROD_W + 2;
  localparam int unsigned Q_W    = ACC_W - WEIGHT_W;
  localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (WEIGHT_W - 1);

  typedef struct packed {
    logic top;
    logic bot;
    logic left;
    logic right;
  } pad_mask_t;

  typedef struct packed {
    logic row_last;
    logic grid_last;
  } tag_t;

  // Registers
  logic [WID_W-1:0]           eff_w_r;
  logic [HGT_W-1:0]           eff_h_r;
  logic signed [SAMPLE_W-1:0] pad_r;
  logic [WEIGHT_W-1:0]        wc_r, we_r, wm_r;

  // Pass counters
  logic [COL_W-1:0] col_r, col_nxt;
  logic [HGT_W-1:0] row_r, row_nxt;
  logic [WID_W-1:0] lag_r, lag_nxt;

  // Entry stage
  logic                       acc0, emit0, pass_end, last_col;
  logic [HGT_W-1:0]           r0;
  logic [COL_W-1:0]           c0;
  pad_mask_t                  mask0;
  tag_t                       tag0;
  logic signed [SAMPLE_W-1:0] val0;
  logic                       dim_wr;

  // Stage 1: line RAM data, window update
  logic                       s1_v_r, s1_emit_r;
  logic [COL_W-1:0]           s1_addr_r;
  logic signed [SAMPLE_W-1:0] s1_val_r;
  pad_mask_t                  s1_mask_r;
  tag_t                       s1_tag_r;
  logic                       fwd_hit_r;
  logic [LINE_W-1:0]          fwd_data_r;
  logic [LINE_W-1:0]          ram_rd, line;
  logic signed [SAMPLE_W-1:0] s1_up, s1_mid;
  logic signed [SAMPLE_W-1:0] cola_r [3];
  logic signed [SAMPLE_W-1:0] colb_r [3];
  logic signed [SAMPLE_W-1:0] newcol [3];
  logic signed [SAMPLE_W-1:0] win    [3][3];
  logic signed [SAMPLE_W-1:0] x      [3][3];
  logic signed [SUM_W-1:0]    sum_c, sum_e, sum_m;
  logic                       s1_wr;

  // Stage 2: class sums
  logic                       s2_v_r;
  logic signed [SUM_W-1:0]    s2_c_r, s2_e_r, s2_m_r;
  tag_t                       s2_tag_r;

  // Stage 3: products
  logic                       s3_v_r;
  logic signed [PROD_W-1:0]   p_c_r, p_e_r, p_m_r;
  tag_t                       s3_tag_r;

  // Stage 4: rounded accumulator
  logic                       s4_v_r;
  logic signed [ACC_W-1:0]    acc_r;
  tag_t                       s4_tag_r;

  // Output register
  logic                       out_valid_r;
  out_item_t                  out_data_r;
  logic signed [Q_W-1:0]      q;
  logic signed [SAMPLE_W-1:0] q_sat;

  // Stage enables
  logic en_out, en4, en3, en2, en1;

  assign en_out   = !out_valid_r || out_ready;
  assign en4      = !s4_v_r || en_out;
  assign en3      = !s3_v_r || en4;
  assign en2      = !s2_v_r || en3;
  assign en1      = !s1_v_r || !s1_emit_r || en2;
  assign in_ready = en1;
  assign acc0     = in_valid && in_ready;

  assign cfg_ready = 1'b1;
  assign dim_wr    = cfg_valid && (cfg_index == CFG_GRID_WIDTH ||
                                   cfg_index == CFG_GRID_HEIGHT);

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WID_W'(RST_WIDTH);
      eff_h_r <= HGT_W'(RST_HEIGHT);
      pad_r   <= RST_PAD;
      wc_r    <= RST_W_CORNER;
      we_r    <= RST_W_EDGE;
      wm_r    <= RST_W_CENTER;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_GRID_WIDTH:    eff_w_r <= WID_W'(clamp_dim(cfg_wdata[DIM_W-1:0], MAX_WIDTH));
        CFG_GRID_HEIGHT:   eff_h_r <= HGT_W'(clamp_dim(cfg_wdata[DIM_W-1:0], MAX_HEIGHT));
        CFG_PAD_VALUE:     pad_r   <= $signed(cfg_wdata[SAMPLE_W-1:0]);
        CFG_WEIGHT_CORNER: wc_r    <= cfg_wdata[WEIGHT_W-1:0];
        CFG_WEIGHT_EDGE:   we_r    <= cfg_wdata[WEIGHT_W-1:0];
        CFG_WEIGHT_CENTER: wm_r    <= cfg_wdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Position of the cell whose window completes with this item
  always_comb begin
    emit0    = lag_r > eff_w_r;
    pass_end = row_r > eff_h_r;
    last_col = WID_W'(col_r) == eff_w_r - WID_W'(1);
    if (col_r != '0) begin
      r0 = row_r - HGT_W'(1);
      c0 = col_r - COL_W'(1);
    end else begin
      r0 = row_r - HGT_W'(2);
      c0 = COL_W'(eff_w_r - WID_W'(1));
    end
    mask0.top      = r0 == '0;
    mask0.bot      = (r0 + HGT_W'(1)) >= eff_h_r;
    mask0.left     = c0 == '0;
    mask0.right    = WID_W'(c0) >= eff_w_r - WID_W'(1);
    tag0.row_last  = WID_W'(c0) == eff_w_r - WID_W'(1);
    tag0.grid_last = tag0.row_last && (r0 == eff_h_r - HGT_W'(1));
    val0 = (in_data.kind == KIND_FLUSH) ? pad_r : in_data.sample;
  end

  // Advance the raster counters; restart on a dimension write
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    lag_nxt = lag_r;
    if (dim_wr) begin
      col_nxt = '0;
      row_nxt = '0;
      lag_nxt = '0;
    end else if (acc0) begin
      if (!emit0) begin
        lag_nxt = lag_r + WID_W'(1);
      end
      if (pass_end) begin
        col_nxt = '0;
        row_nxt = '0;
        lag_nxt = '0;
      end else if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + HGT_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      lag_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      lag_r <= lag_nxt;
    end
  end

  // Line RAM: upper half holds the row above, lower half the current row
  assign s1_wr = en1 && s1_v_r;

  hsc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (s1_wr),
    .wr_addr (s1_addr_r),
    .wr_data ({s1_mid, s1_val_r}),
    .rd_en   (en1),
    .rd_addr (col_r),
    .rd_data (ram_rd)
  );

  // Forward the last write when the next item reads the same entry
  assign line   = fwd_hit_r ? fwd_data_r : ram_rd;
  assign s1_up  = $signed(line[LINE_W-1:SAMPLE_W]);
  assign s1_mid = $signed(line[SAMPLE_W-1:0]);

  // Build the window, replace cells outside the grid, sum by weight class
  always_comb begin
    newcol[0] = s1_up;
    newcol[1] = s1_mid;
    newcol[2] = s1_val_r;
    for (int dr = 0; dr < 3; dr++) begin
      win[dr][0] = cola_r[dr];
      win[dr][1] = colb_r[dr];
      win[dr][2] = newcol[dr];
      for (int dc = 0; dc < 3; dc++) begin
        if ((dr == 0 && s1_mask_r.top) || (dr == 2 && s1_mask_r.bot) ||
            (dc == 0 && s1_mask_r.left) || (dc == 2 && s1_mask_r.right)) begin
          x[dr][dc] = pad_r;
        end else begin
          x[dr][dc] = win[dr][dc];
        end
      end
    end
    sum_c = SUM_W'(x[0][0]) + SUM_W'(x[0][2]) + SUM_W'(x[2][0]) + SUM_W'(x[2][2]);
    sum_e = SUM_W'(x[0][1]) + SUM_W'(x[1][0]) + SUM_W'(x[1][2]) + SUM_W'(x[2][1]);
    sum_m = SUM_W'(x[1][1]);
  end

  // Stage 1 and the window columns
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else if (en1) begin
      s1_v_r    <= acc0;
      fwd_hit_r <= s1_v_r && acc0 && (s1_addr_r == col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_emit_r  <= emit0;
      s1_addr_r  <= col_r;
      s1_val_r   <= val0;
      s1_mask_r  <= mask0;
      s1_tag_r   <= tag0;
      fwd_data_r <= {s1_mid, s1_val_r};
    end
    if (s1_wr) begin
      for (int k = 0; k < 3; k++) begin
        cola_r[k] <= colb_r[k];
        colb_r[k] <= newcol[k];
      end
    end
  end

  // Result stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      s4_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en2)    s2_v_r      <= s1_v_r && s1_emit_r;
      if (en3)    s3_v_r      <= s2_v_r;
      if (en4)    s4_v_r      <= s3_v_r;
      if (en_out) out_valid_r <= s4_v_r;
    end
  end

  // Round to nearest (ties up) and saturate
  always_comb begin
    q = acc_r[ACC_W-1:WEIGHT_W];
    if (q[Q_W-1:SAMPLE_W-1] == '0 || q[Q_W-1:SAMPLE_W-1] == '1) begin
      q_sat = q[SAMPLE_W-1:0];
    end else if (q[Q_W-1]) begin
      q_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      q_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_c_r   <= sum_c;
      s2_e_r   <= sum_e;
      s2_m_r   <= sum_m;
      s2_tag_r <= s1_tag_r;
    end
    if (en3) begin
      p_c_r    <= s2_c_r * $signed({1'b0, wc_r});
      p_e_r    <= s2_e_r * $signed({1'b0, we_r});
      p_m_r    <= s2_m_r * $signed({1'b0, wm_r});
      s3_tag_r <= s2_tag_r;
    end
    if (en4) begin
      acc_r    <= ACC_W'(p_c_r) + ACC_W'(p_e_r) + ACC_W'(p_m_r) + $signed(ROUND_BIAS);
      s4_tag_r <= s3_tag_r;
    end
    if (en_out) begin
      out_data_r.value     <= q_sat;
      out_data_r.row_last  <= s4_tag_r.row_last;
      out_data_r.grid_last <= s4_tag_r.grid_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Checks
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    WID_W'(col_r) < eff_w_r)
    else $error("column counter beyond grid width");

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= eff_h_r + HGT_W'(1))
    else $error("row counter beyond pass end");

  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lag_r <= eff_w_r + WID_W'(1))
    else $error("lag counter overran");

  // Two items in a row share an entry only at column zero
  a_fwd_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_hit_r |-> (s1_v_r && s1_addr_r == '0))
    else $error("line forwarding away from column zero");

  a_grid_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.grid_last) |-> out_data.row_last)
    else $error("grid end without row end");

endmodule
